>>> sv/qslerp_pkg.sv
`default_nettype none

package qslerp_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 15;          // fraction bits of the I/O values
  localparam int IFB       = 30;          // fraction bits of the internal Q30 values
  localparam int CORDIC_STAGES_DEF = 16;

  // Internal widths
  localparam int TW         = 31;         // Q30 magnitude up to and including 1.0
  localparam int SQW        = 62;         // square root working width
  localparam int SQRT_STEPS = 31;         // one result bit per step for a 61-bit radicand
  localparam int CW         = 36;         // CORDIC x/y
  localparam int ZW         = 34;         // CORDIC angle
  localparam int DIV_STEPS  = 32;         // quotient bits
  localparam int RW         = 66;         // divider remainder
  localparam int QW         = 32;
  localparam int KW         = 33;         // signed weight, +-2.0 in Q30

  localparam logic [TW-1:0] ONE30    = TW'(1) << IFB;
  localparam logic [15:0]   THR_RESET = 16'd32765;
  localparam logic signed [CW-1:0] GAIN_INV = 36'sh0_26DD_3B6A;

  // arctan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic [4:0] idx;
    idx = i[4:0];
    return $signed({2'b00, ATAN_TAB[idx]});
  endfunction

  // Channel payloads
  typedef struct packed {
    logic signed [15:0] start_w;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_w;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic [15:0]        blend;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_t;

  typedef logic [15:0] cfg_t;

  // Per-transaction data travelling alongside the cell chains
  typedef struct packed {
    logic [3:0][15:0] s;       // start components
    logic [3:0][16:0] e;       // end components, negated for the short arc
    logic [TW-1:0]    t30;     // blend in Q30
    logic [TW-1:0]    cosv;
    logic [TW-1:0]    sinv;
    logic             thr_hit; // cosine above threshold
    logic             lin;     // linear weights in use
  } side_t;

endpackage

`default_nettype wire

>>> sv/qslerp_if.sv
`default_nettype none

interface qslerp_if #(parameter type T = logic [15:0]) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/qslerp_sqrt_cell.sv
`default_nettype none

// One step of the digit-by-digit square root
module qslerp_sqrt_cell import qslerp_pkg::*; #(
  parameter int BIT_POS = 60
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire side_t          side_i,
  input  wire logic [SQW-1:0] n_i,
  input  wire logic [SQW-1:0] r_i,
  output logic                valid_o,
  output side_t               side_o,
  output logic [SQW-1:0]      n_o,
  output logic [SQW-1:0]      r_o
);

  localparam logic [SQW-1:0] BITV = SQW'(1) << BIT_POS;

  logic [SQW-1:0] trial;
  logic           take;
  logic [SQW-1:0] n_d, r_d;

  // trial subtract
  always_comb begin
    trial = r_i + BITV;
    take  = n_i >= trial;
    n_d   = take ? n_i - trial : n_i;
    r_d   = take ? (r_i >> 1) + BITV : r_i >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      n_o    <= n_d;
      r_o    <= r_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/qslerp_cordic_cell.sv
`default_nettype none

// One CORDIC micro-rotation, vectoring or rotation mode, over LANES lanes
module qslerp_cordic_cell import qslerp_pkg::*; #(
  parameter int IDX    = 0,
  parameter int LANES  = 1,
  parameter bit ROTATE = 1'b0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire side_t                 side_i,
  input  wire logic signed [CW-1:0]  x_i [LANES],
  input  wire logic signed [CW-1:0]  y_i [LANES],
  input  wire logic signed [ZW-1:0]  z_i [LANES],
  output logic                       valid_o,
  output side_t                      side_o,
  output logic signed [CW-1:0]       x_o [LANES],
  output logic signed [CW-1:0]       y_o [LANES],
  output logic signed [ZW-1:0]       z_o [LANES]
);

  localparam logic signed [ZW-1:0] ANG = atan_val(IDX);

  logic signed [CW-1:0] x_d [LANES];
  logic signed [CW-1:0] y_d [LANES];
  logic signed [ZW-1:0] z_d [LANES];

  // direction from the angle (rotation) or from the sign of y (vectoring)
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [CW-1:0] dx, dy;
      logic up;
      dx = y_i[l] >>> IDX;
      dy = x_i[l] >>> IDX;
      up = ROTATE ? !z_i[l][ZW-1] : y_i[l][CW-1];
      if (up) begin
        x_d[l] = x_i[l] - dx;
        y_d[l] = y_i[l] + dy;
        z_d[l] = z_i[l] - ANG;
      end else begin
        x_d[l] = x_i[l] + dx;
        y_d[l] = y_i[l] - dy;
        z_d[l] = z_i[l] + ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/qslerp_div_cell.sv
`default_nettype none

// One restoring-division step; the divisor is the sine carried in the side data
module qslerp_div_cell import qslerp_pkg::*; #(
  parameter int SH    = 31,
  parameter int LANES = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire side_t         side_i,
  input  wire logic [RW-1:0] rem_i [LANES],
  input  wire logic [QW-1:0] q_i   [LANES],
  input  wire logic          neg_i [LANES],
  input  wire logic          ovf_i [LANES],
  output logic               valid_o,
  output side_t              side_o,
  output logic [RW-1:0]      rem_o [LANES],
  output logic [QW-1:0]      q_o   [LANES],
  output logic               neg_o [LANES],
  output logic               ovf_o [LANES]
);

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_d [LANES];
  logic [QW-1:0] q_d   [LANES];

  always_comb begin
    trial = RW'(side_i.sinv) << SH;
    for (int l = 0; l < LANES; l++) begin
      if (rem_i[l] >= trial) begin
        rem_d[l] = rem_i[l] - trial;
        q_d[l]   = q_i[l] | (QW'(1) << SH);
      end else begin
        rem_d[l] = rem_i[l];
        q_d[l]   = q_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rem_o  <= rem_d;
      q_o    <= q_d;
      neg_o  <= neg_i;
      ovf_o  <= ovf_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/quaternion_slerp_top.sv
// Quaternion slerp, fully pipelined.
// Channels: in_i carries start and end quaternions (signed Q1.15) and the
// blend t (unsigned Q1.15, above 1.0 treated as 1.0); out_o carries the
// interpolated quaternion, each component rounded and saturated to Q1.15.
// cfg_i writes the linear threshold (unsigned Q1.15); it is always ready
// and should only be written while no transaction is in flight.
// Throughput: one transaction per cycle while the pipe is not held. The
// stages are chains of cells: 31 square root steps, CORDIC_STAGES vectoring
// steps, CORDIC_STAGES rotation steps (both sines side by side), 32 divider
// steps (both weights side by side), plus nine further register stages for
// products, sums, saturation and output. Every stage advances together.
// When the receiver stalls with a result waiting in the output register, a
// spare register takes the next result; once that is full the whole pipe
// holds and in_i.ready drops. in_i.ready comes from a register, so it has
// no path from out_o.ready.
// Reset clears all valid bits and loads the threshold with 0.9999.
`default_nettype none

module quaternion_slerp_top import qslerp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qslerp_if.sink    in_i,
  qslerp_if.sink    cfg_i,
  qslerp_if.source  out_o
);

  localparam int DSR = (2 * FRAC_BITS > IFB) ? 2 * FRAC_BITS - IFB : 0;
  localparam int DSL = (2 * FRAC_BITS < IFB) ? IFB - 2 * FRAC_BITS : 0;
  localparam int TSL = IFB - FRAC_BITS;

  logic en;
  logic out_valid_q;
  out_t out_q;
  logic skid_v_q;
  out_t skid_q;

  // pipe moves unless the spare register holds a stalled result
  assign en = !skid_v_q;
  assign in_i.ready = en;

  // threshold register
  logic [15:0] thr_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  // stage 1: component products, blend clamp
  logic               p1_v_q;
  logic signed [31:0] prod_q [4];
  side_t              p1_side_q;
  in_t                din;
  logic [31:0]        t_cl;
  side_t              p1_side_d;

  assign din = in_i.data;

  always_comb begin
    t_cl = (32'(din.blend) > (32'(1) << FRAC_BITS)) ? (32'(1) << FRAC_BITS) : 32'(din.blend);
    p1_side_d = '0;
    p1_side_d.s[0] = din.start_w;
    p1_side_d.s[1] = din.start_x;
    p1_side_d.s[2] = din.start_y;
    p1_side_d.s[3] = din.start_z;
    p1_side_d.e[0] = 17'(din.end_w);
    p1_side_d.e[1] = 17'(din.end_x);
    p1_side_d.e[2] = 17'(din.end_y);
    p1_side_d.e[3] = 17'(din.end_z);
    p1_side_d.t30  = TW'(t_cl << TSL);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[0] <= din.start_w * din.end_w;
      prod_q[1] <= din.start_x * din.end_x;
      prod_q[2] <= din.start_y * din.end_y;
      prod_q[3] <= din.start_z * din.end_z;
      p1_side_q <= p1_side_d;
    end
  end

  // stage 2: dot product, short-arc flip, Q30 cosine, threshold test
  logic               p2_v_q;
  side_t              p2_side_q;
  side_t              p2_side_d;
  logic signed [33:0] dot;
  logic [32:0]        dmag;
  logic [63:0]        mag64;
  logic [47:0]        thr30;

  always_comb begin
    dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    dmag = dot[33] ? 33'(-dot) : 33'(dot);
    mag64 = (64'(dmag) >> DSR) << DSL;
    thr30 = 48'(thr_q) << TSL;
    p2_side_d = p1_side_q;
    for (int c = 0; c < 4; c++) begin
      if (dot[33]) begin
        p2_side_d.e[c] = -p1_side_q.e[c];
      end
    end
    p2_side_d.cosv = (mag64 > 64'(ONE30)) ? ONE30 : mag64[TW-1:0];
    p2_side_d.thr_hit = 48'(p2_side_d.cosv) > thr30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_side_q <= p2_side_d;
    end
  end

  // stage 3: cosine squared
  logic           p3_v_q;
  side_t          p3_side_q;
  logic [SQW-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_side_q <= p2_side_q;
      sq_q      <= SQW'(p2_side_q.cosv) * SQW'(p2_side_q.cosv);
    end
  end

  // stage 4: radicand 1 - cos^2
  logic           p4_v_q;
  side_t          p4_side_q;
  logic [SQW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_side_q <= p3_side_q;
      rad_q     <= (SQW'(1) << (2 * IFB)) - sq_q;
    end
  end

  // square root chain
  logic           sq_v    [SQRT_STEPS+1];
  side_t          sq_side [SQRT_STEPS+1];
  logic [SQW-1:0] sq_n    [SQRT_STEPS+1];
  logic [SQW-1:0] sq_r    [SQRT_STEPS+1];

  assign sq_v[0]    = p4_v_q;
  assign sq_side[0] = p4_side_q;
  assign sq_n[0]    = rad_q;
  assign sq_r[0]    = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qslerp_sqrt_cell #(.BIT_POS(2 * IFB - 2 * k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .side_i  (sq_side[k]),
      .n_i     (sq_n[k]),
      .r_i     (sq_r[k]),
      .valid_o (sq_v[k+1]),
      .side_o  (sq_side[k+1]),
      .n_o     (sq_n[k+1]),
      .r_o     (sq_r[k+1])
    );
  end

  // vectoring chain: angle of (cos, sin)
  logic                 vec_v    [CORDIC_STAGES+1];
  side_t                vec_side [CORDIC_STAGES+1];
  logic signed [CW-1:0] vec_x    [CORDIC_STAGES+1][1];
  logic signed [CW-1:0] vec_y    [CORDIC_STAGES+1][1];
  logic signed [ZW-1:0] vec_z    [CORDIC_STAGES+1][1];
  side_t                vec_head;

  always_comb begin
    vec_head      = sq_side[SQRT_STEPS];
    vec_head.sinv = sq_r[SQRT_STEPS][TW-1:0];
  end

  assign vec_v[0]    = sq_v[SQRT_STEPS];
  assign vec_side[0] = vec_head;
  assign vec_x[0][0] = $signed(CW'(vec_head.cosv));
  assign vec_y[0][0] = $signed(CW'(vec_head.sinv));
  assign vec_z[0][0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    qslerp_cordic_cell #(.IDX(i), .LANES(1), .ROTATE(1'b0)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vec_v[i]),
      .side_i  (vec_side[i]),
      .x_i     (vec_x[i]),
      .y_i     (vec_y[i]),
      .z_i     (vec_z[i]),
      .valid_o (vec_v[i+1]),
      .side_o  (vec_side[i+1]),
      .x_o     (vec_x[i+1]),
      .y_o     (vec_y[i+1]),
      .z_o     (vec_z[i+1])
    );
  end

  // stage A: the two partial angles, linear decision
  logic            pa_v_q;
  side_t           pa_side_q;
  logic [TW-1:0]   ang_q [2];
  logic [TW-1:0]   om;
  logic [2*TW-1:0] pr1, pr2;
  side_t           pa_side_d;

  always_comb begin
    om  = vec_z[CORDIC_STAGES][0][ZW-1] ? '0 : vec_z[CORDIC_STAGES][0][TW-1:0];
    pr1 = (2*TW)'(ONE30 - vec_side[CORDIC_STAGES].t30) * (2*TW)'(om);
    pr2 = (2*TW)'(vec_side[CORDIC_STAGES].t30) * (2*TW)'(om);
    pa_side_d = vec_side[CORDIC_STAGES];
    pa_side_d.lin = vec_side[CORDIC_STAGES].thr_hit || (vec_side[CORDIC_STAGES].sinv == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_side_q <= pa_side_d;
      ang_q[0]  <= pr1[IFB +: TW];
      ang_q[1]  <= pr2[IFB +: TW];
    end
  end

  // rotation chain: both sines side by side
  logic                 rot_v    [CORDIC_STAGES+1];
  side_t                rot_side [CORDIC_STAGES+1];
  logic signed [CW-1:0] rot_x    [CORDIC_STAGES+1][2];
  logic signed [CW-1:0] rot_y    [CORDIC_STAGES+1][2];
  logic signed [ZW-1:0] rot_z    [CORDIC_STAGES+1][2];

  assign rot_v[0]    = pa_v_q;
  assign rot_side[0] = pa_side_q;
  for (genvar l = 0; l < 2; l++) begin : g_rot_head
    assign rot_x[0][l] = GAIN_INV;
    assign rot_y[0][l] = '0;
    assign rot_z[0][l] = $signed(ZW'(ang_q[l]));
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    qslerp_cordic_cell #(.IDX(i), .LANES(2), .ROTATE(1'b1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rot_v[i]),
      .side_i  (rot_side[i]),
      .x_i     (rot_x[i]),
      .y_i     (rot_y[i]),
      .z_i     (rot_z[i]),
      .valid_o (rot_v[i+1]),
      .side_o  (rot_side[i+1]),
      .x_o     (rot_x[i+1]),
      .y_o     (rot_y[i+1]),
      .z_o     (rot_z[i+1])
    );
  end

  // stage D: dividend magnitude, sign and overflow of the quotient
  logic          pd_v_q;
  side_t         pd_side_q;
  logic [RW-1:0] pd_rem_q [2];
  logic          pd_neg_q [2];
  logic          pd_ovf_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_side_q <= rot_side[CORDIC_STAGES];
      for (int l = 0; l < 2; l++) begin
        logic signed [CW-1:0] yv;
        logic [CW-1:0]        ym;
        yv = rot_y[CORDIC_STAGES][l];
        ym = yv[CW-1] ? CW'(-yv) : CW'(yv);
        pd_neg_q[l] <= yv[CW-1];
        pd_ovf_q[l] <= (38'(ym) >= (38'(rot_side[CORDIC_STAGES].sinv) << 2));
        pd_rem_q[l] <= RW'(ym) << IFB;
      end
    end
  end

  // divider chain: both weights side by side
  logic          dv_v    [DIV_STEPS+1];
  side_t         dv_side [DIV_STEPS+1];
  logic [RW-1:0] dv_rem  [DIV_STEPS+1][2];
  logic [QW-1:0] dv_q    [DIV_STEPS+1][2];
  logic          dv_neg  [DIV_STEPS+1][2];
  logic          dv_ovf  [DIV_STEPS+1][2];

  assign dv_v[0]    = pd_v_q;
  assign dv_side[0] = pd_side_q;
  assign dv_rem[0]  = pd_rem_q;
  assign dv_neg[0]  = pd_neg_q;
  assign dv_ovf[0]  = pd_ovf_q;
  assign dv_q[0][0] = '0;
  assign dv_q[0][1] = '0;

  for (genvar m = 0; m < DIV_STEPS; m++) begin : g_div
    qslerp_div_cell #(.SH(DIV_STEPS - 1 - m), .LANES(2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[m]),
      .side_i  (dv_side[m]),
      .rem_i   (dv_rem[m]),
      .q_i     (dv_q[m]),
      .neg_i   (dv_neg[m]),
      .ovf_i   (dv_ovf[m]),
      .valid_o (dv_v[m+1]),
      .side_o  (dv_side[m+1]),
      .rem_o   (dv_rem[m+1]),
      .q_o     (dv_q[m+1]),
      .neg_o   (dv_neg[m+1]),
      .ovf_o   (dv_ovf[m+1])
    );
  end

  // stage K: saturate weights, select linear or spherical
  logic                 pk_v_q;
  side_t                pk_side_q;
  logic signed [KW-1:0] k1_q, k2_q;
  logic signed [KW-1:0] ks [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [QW-1:0] qv, kmag;
      qv   = dv_q[DIV_STEPS][l];
      kmag = (dv_ovf[DIV_STEPS][l] || qv > (QW'(1) << (QW - 1))) ? (QW'(1) << (QW - 1)) : qv;
      ks[l] = dv_neg[DIV_STEPS][l] ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_side_q <= dv_side[DIV_STEPS];
      if (dv_side[DIV_STEPS].lin) begin
        k1_q <= $signed(KW'(ONE30 - dv_side[DIV_STEPS].t30));
        k2_q <= $signed(KW'(dv_side[DIV_STEPS].t30));
      end else begin
        k1_q <= ks[0];
        k2_q <= ks[1];
      end
    end
  end

  // stage M: weighted components
  logic               pm_v_q;
  logic signed [48:0] pa_q [4];
  logic signed [49:0] pb_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        pa_q[c] <= $signed(pk_side_q.s[c]) * k1_q;
        pb_q[c] <= $signed(pk_side_q.e[c]) * k2_q;
      end
    end
  end

  // output stage: sum, round half up, saturate
  logic signed [15:0] res [4];
  out_t               res_pk;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [51:0] sum;
      logic signed [21:0] shv;
      sum = 52'(pa_q[c]) + 52'(pb_q[c]) + (52'sd1 <<< (IFB - 1));
      shv = 22'(sum >>> IFB);
      if (shv > 22'sd32767) begin
        res[c] = 16'sh7FFF;
      end else if (shv < -22'sd32768) begin
        res[c] = 16'sh8000;
      end else begin
        res[c] = shv[15:0];
      end
    end
    res_pk.out_w = res[0];
    res_pk.out_x = res[1];
    res_pk.out_y = res[2];
    res_pk.out_z = res[3];
  end

  // output register, with a spare that catches the result arriving in a stall
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_q <= skid_v_q ? skid_q : res_pk;
    end else if (en && pm_v_q) begin
      skid_q <= res_pk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= skid_v_q || pm_v_q;
      skid_v_q    <= 1'b0;
    end else if (en && pm_v_q) begin
      skid_v_q    <= 1'b1;
    end
  end

  // valid bits of the register stages outside the cell chains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      p4_v_q      <= 1'b0;
      pa_v_q      <= 1'b0;
      pd_v_q      <= 1'b0;
      pk_v_q      <= 1'b0;
      pm_v_q      <= 1'b0;
    end else if (en) begin
      p1_v_q      <= in_i.valid;
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      p4_v_q      <= p3_v_q;
      pa_v_q      <= vec_v[CORDIC_STAGES];
      pd_v_q      <= rot_v[CORDIC_STAGES];
      pk_v_q      <= dv_v[DIV_STEPS];
      pm_v_q      <= pk_v_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTH
  // cosine never exceeds 1.0 after saturation
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |-> (p2_side_q.cosv <= ONE30))
    else $error("cosine above 1.0");

  // the square root of 1 - cos^2 never exceeds 1.0
  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v[SQRT_STEPS] |-> (sq_r[SQRT_STEPS] <= SQW'(ONE30)))
    else $error("sine above 1.0");

  // linear weights always sum to one
  a_lin_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pk_v_q && pk_side_q.lin) |-> ((k1_q + k2_q) == $signed(KW'(ONE30))))
    else $error("linear weights do not sum to one");
`endif

endmodule

`default_nettype wire

>>> tb/sv/quaternion_slerp_top_tb.sv
`default_nettype none

module quaternion_slerp_top_tb;
  import qslerp_pkg::*;

  localparam int LATENCY = 104;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qslerp_if #(.T(in_t))  in_ch ();
  qslerp_if #(.T(cfg_t)) cfg_ch ();
  qslerp_if #(.T(out_t)) out_ch ();

  quaternion_slerp_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [15:0] thr_model;
  out_t        expected_q[$];
  int          err_cnt = 0;
  bit          rx_stall_long = 1'b0;

  // Q30 arctangent table
  function automatic longint atan_q30(input int i);
    return longint'(ATAN_TAB[i & 31]);
  endfunction

  // floor shift for signed values
  function automatic longint shr_floor(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint angle_of(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q30(i);
      end else begin
        x -= dx; y += dy; z -= atan_q30(i);
      end
    end
    return z;
  endfunction

  function automatic longint sine_of(input longint a);
    longint x, y, z, dx, dy;
    x = 64'h26DD3B6A;
    y = 0;
    z = a;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    return y;
  endfunction

  function automatic longint blend_weight(input longint sa, input longint so);
    longint k;
    k = (sa * (64'sd1 <<< 30)) / so;
    if (k > (64'sd1 <<< 31)) k = 64'sd1 <<< 31;
    if (k < -(64'sd1 <<< 31)) k = -(64'sd1 <<< 31);
    return k;
  endfunction

  // Expected slerp of one transaction
  function automatic out_t slerp_predict(input in_t q, input logic [15:0] thr);
    longint s[4], e[4], dot, k1, k2, t30, thr30, cosv, sinv, om, v;
    longint unsigned t, mag, a1, a2;
    logic signed [15:0] res[4];
    out_t o;
    s[0] = q.start_w; s[1] = q.start_x; s[2] = q.start_y; s[3] = q.start_z;
    e[0] = q.end_w;   e[1] = q.end_x;   e[2] = q.end_y;   e[3] = q.end_z;
    dot = 0;
    for (int c = 0; c < 4; c++) dot += s[c] * e[c];
    t = q.blend;
    if (t > 32768) t = 32768;
    t30 = longint'(t) <<< 15;
    thr30 = longint'(thr) <<< 15;
    if (dot < 0) begin
      dot = -dot;
      for (int c = 0; c < 4; c++) e[c] = -e[c];
    end
    mag = dot;
    if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
    cosv = mag;
    k1 = (64'sd1 <<< 30) - t30;
    k2 = t30;
    if (!(cosv > thr30)) begin
      sinv = int_sqrt((64'd1 << 60) - mag * mag);
      if (sinv != 0) begin
        om = angle_of(sinv, cosv);
        if (om < 0) om = 0;
        a1 = (longint'((64'sd1 <<< 30) - t30) * om) >> 30;
        a2 = (t30 * om) >> 30;
        k1 = blend_weight(sine_of(a1), sinv);
        k2 = blend_weight(sine_of(a2), sinv);
      end
    end
    for (int c = 0; c < 4; c++) begin
      v = s[c] * k1 + e[c] * k2;
      v = (v + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res[c] = v[15:0];
    end
    o.out_w = res[0]; o.out_x = res[1]; o.out_y = res[2]; o.out_z = res[3];
    return o;
  endfunction

  // Directed stimulus; has_exp marks rows with a hand-typed result
  typedef struct {
    in_t  item;
    bit   has_exp;
    out_t exp;
  } slerp_row_t;

  slerp_row_t directed[$];

  function automatic in_t mk(input int sw, sx, sy, sz, ew, ex, ey, ez, b);
    in_t q;
    q.start_w = 16'(sw); q.start_x = 16'(sx); q.start_y = 16'(sy); q.start_z = 16'(sz);
    q.end_w = 16'(ew); q.end_x = 16'(ex); q.end_y = 16'(ey); q.end_z = 16'(ez);
    q.blend = 16'(b);
    return q;
  endfunction

  function automatic out_t mko(input int w, x, y, z);
    out_t o;
    o.out_w = 16'(w); o.out_x = 16'(x); o.out_y = 16'(y); o.out_z = 16'(z);
    return o;
  endfunction

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Pair of near-unit quaternions with random directions
  function automatic in_t rnd_unit_pair();
    in_t q;
    real v[8], n1, n2;
    for (int i = 0; i < 8; i++) v[i] = real'($urandom_range(0, 20000)) - 10000.0;
    if ($urandom_range(0, 3) == 0)
      for (int i = 4; i < 8; i++) v[i] = v[i - 4] + real'($urandom_range(0, 200)) - 100.0;
    n1 = $sqrt(v[0]*v[0] + v[1]*v[1] + v[2]*v[2] + v[3]*v[3]) + 1.0;
    n2 = $sqrt(v[4]*v[4] + v[5]*v[5] + v[6]*v[6] + v[7]*v[7]) + 1.0;
    q.start_w = 16'(int'(v[0] / n1 * 32767.0));
    q.start_x = 16'(int'(v[1] / n1 * 32767.0));
    q.start_y = 16'(int'(v[2] / n1 * 32767.0));
    q.start_z = 16'(int'(v[3] / n1 * 32767.0));
    q.end_w   = 16'(int'(v[4] / n2 * 32767.0));
    q.end_x   = 16'(int'(v[5] / n2 * 32767.0));
    q.end_y   = 16'(int'(v[6] / n2 * 32767.0));
    q.end_z   = 16'(int'(v[7] / n2 * 32767.0));
    q.blend = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    return q;
  endfunction

  function automatic in_t rnd_noise();
    in_t q;
    q.start_w = rnd_comp(); q.start_x = rnd_comp();
    q.start_y = rnd_comp(); q.start_z = rnd_comp();
    q.end_w = rnd_comp(); q.end_x = rnd_comp();
    q.end_y = rnd_comp(); q.end_z = rnd_comp();
    q.blend = 16'($urandom());
    return q;
  endfunction

  // Random gap: mostly short, occasionally long
  function automatic int rnd_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one transaction and record its expectation; valid stays high
  // into the next transaction unless a gap follows
  task automatic send_item(input in_t q, input bit has_exp, input out_t hand);
    int gap;
    gap = rnd_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.data  <= q;
    in_ch.valid <= 1'b1;
    if (has_exp) expected_q.push_back(hand);
    else expected_q.push_back(slerp_predict(q, thr_model));
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected result has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Wait until the pipe is empty, then write the threshold
  task automatic write_threshold(input logic [15:0] val);
    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    thr_model = val;
  endtask

  // Receiver: random back-pressure, mostly short stalls, a few long
  initial begin
    int rx_gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      rx_gap = rnd_gap();
      if (!rx_stall_long && rx_gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_ch.data);
        err_cnt++;
      end else begin
        out_t x;
        x = expected_q.pop_front();
        if (x.out_w !== out_ch.data.out_w) begin
          $display("%0t: out_w expected %0d actual %0d", $time, x.out_w, out_ch.data.out_w);
          err_cnt++;
        end
        if (x.out_x !== out_ch.data.out_x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, x.out_x, out_ch.data.out_x);
          err_cnt++;
        end
        if (x.out_y !== out_ch.data.out_y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, x.out_y, out_ch.data.out_y);
          err_cnt++;
        end
        if (x.out_z !== out_ch.data.out_z) begin
          $display("%0t: out_z expected %0d actual %0d", $time, x.out_z, out_ch.data.out_z);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence
  initial begin
    logic [15:0] thr_list[6];
    out_t none;
    int tail;
    none = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    thr_model    = THR_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identical unit quaternions take the linear path
    directed.push_back('{mk(32767, 0, 0, 0, 32767, 0, 0, 0, 0), 1, mko(32767, 0, 0, 0)});
    directed.push_back('{mk(32767, 0, 0, 0, 32767, 0, 0, 0, 32768), 1, mko(32767, 0, 0, 0)});
    // blend above one saturates
    directed.push_back('{mk(32767, 0, 0, 0, 32767, 0, 0, 0, 65535), 1, mko(32767, 0, 0, 0)});
    // negative cosine flips the end quaternion
    directed.push_back('{mk(32767, 0, 0, 0, -32767, 0, 0, 0, 32768), 1, mko(32767, 0, 0, 0)});
    // zero inputs: spherical weights, but every component stays zero
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 16384), 1, mko(0, 0, 0, 0)});
    // orthogonal pairs, spherical path
    directed.push_back('{mk(32767, 0, 0, 0, 0, 32767, 0, 0, 16384), 0, none});
    directed.push_back('{mk(0, 0, 32767, 0, 0, 0, 0, -32767, 8192), 0, none});
    directed.push_back('{mk(23170, 23170, 0, 0, 0, 0, 23170, 23170, 24576), 0, none});
    // non-unit magnitudes: cosine saturates
    directed.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            16384), 0, none});
    directed.push_back('{mk(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                            0), 0, none});
    // small and moderate cosines, spherical path
    directed.push_back('{mk(100, 0, 0, 0, 0, 100, 0, 0, 16384), 0, none});
    directed.push_back('{mk(32767, -32768, 1, -1, 1, -1, 32767, -32768, 1), 0, none});
    directed.push_back('{mk(20000, 20000, 10000, 5000, 20100, 19900, 10050, 4950, 12345),
                         0, none});
    foreach (directed[i]) send_item(directed[i].item, directed[i].has_exp, directed[i].exp);

    // threshold settings, extremes included
    thr_list = '{16'd0, 16'd32768, 16'd16384, 16'd32700, 16'd65535, THR_RESET};
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thr_list[ph]);
      for (int n = 0; n < 66; n++)
        send_item(($urandom_range(0, 9) < 8) ? rnd_unit_pair() : rnd_noise(), 0, none);
      if (ph == 2) begin
        // hold off until the pipe has drained
        drain();
        rx_stall_long = 1'b1;
        repeat (20) send_item(rnd_unit_pair(), 0, none);
        rx_stall_long = 1'b0;
      end
    end

    in_ch.valid <= 1'b0;
    tail = 0;
    while (expected_q.size() != 0 && tail < 200000) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
